// ===== hw/rtl/rld_pkg.sv =====
// rld_pkg: shared types and constants for the rle literal/run decoder
// no dependencies; imported by the interfaces, rld_step and the top level

package rld_pkg;

  // width of the produced byte counter, the literal counter and the length limit
  localparam int LENGTH_BITS = 32;

  localparam int CFG_DATA_W   = 32;
  localparam int CFG_ADDR_W   = 3;
  localparam int BYTE_W       = 8;
  localparam int REPEAT_W     = 32;
  localparam int HDR_ACC_W    = 64;
  localparam int HDR_SHIFT_W  = 4;
  // index of the last header byte that still lands in the accumulator
  localparam int HDR_LAST     = 9;
  localparam int HDR_DIGIT_W  = 7;

  // configuration register indexes
  typedef enum logic [CFG_ADDR_W-3:0] {
    REG_EXPECTED_LENGTH = 1'b0,
    REG_UNMAPPED        = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    MODE_HEADER  = 2'd0,
    MODE_RUN     = 2'd1,
    MODE_LITERAL = 2'd2,
    MODE_ERROR   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_DATA     = 3'd0,
    ST_DONE     = 3'd1,
    ST_OVERFLOW = 3'd2,
    ST_ZERO     = 3'd3,
    ST_EXCEEDS  = 3'd4,
    ST_TRUNC    = 3'd5,
    ST_MISMATCH = 3'd6
  } status_t;

  typedef struct packed {
    mode_t                   mode;
    logic [HDR_ACC_W-1:0]    hdr_accum;
    logic [HDR_SHIFT_W-1:0]  hdr_shift;
    logic [LENGTH_BITS-1:0]  literal_left;
    logic [LENGTH_BITS-1:0]  produced;
    status_t                 err_code;
  } rld_state_t;

  typedef struct packed {
    logic                valid;
    logic [BYTE_W-1:0]   out_byte;
    logic [REPEAT_W-1:0] repeat_count;
    status_t             status;
  } rld_result_t;

endpackage

// ===== hw/rtl/rld_in_if.sv =====
// rld_in_if: valid/ready channel carrying one encoded byte or an end marker
// depends on rld_pkg

interface rld_in_if import rld_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] enc_byte;
  logic              end_mark;

  modport source (output valid, output enc_byte, output end_mark, input ready);
  modport sink   (input valid, input enc_byte, input end_mark, output ready);
endinterface

// ===== hw/rtl/rld_out_if.sv =====
// rld_out_if: valid/ready channel carrying one decoded byte/run or a status
// depends on rld_pkg

interface rld_out_if import rld_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [BYTE_W-1:0]   out_byte;
  logic [REPEAT_W-1:0] repeat_count;
  status_t             status;

  modport source (output valid, output out_byte, output repeat_count, output status,
                  input ready);
  modport sink   (input valid, input out_byte, input repeat_count, input status,
                  output ready);
endinterface

// ===== hw/rtl/rle_literal_run_decoder_unit.sv =====
// rle_literal_run_decoder_unit: top level of the byte rle decoder with varint headers
// depends on rld_pkg, rld_in_if, rld_out_if and rld_step
//
// Takes one encoded byte (or an end marker) per cycle while input ready is high,
// and returns at most one result per input transfer: a literal byte with
// repeat_count 1, a run byte with its repeat count, or a status (done, length
// mismatch, or an error). A result appears in the output register in the cycle
// after the input transfer; the output register is the only stage, so input ready
// stays high while that register is empty or being drained in the same cycle.
// After an error the decoder stays silent, also on the end marker, which always
// returns it to a fresh column. The expected column length lives at byte address
// 0x0 of the APB port and should be written only while the decoder is idle.

module rle_literal_run_decoder_unit import rld_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  rld_in_if.sink                 in_ch,
  rld_out_if.source              out_ch,
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [CFG_DATA_W-1:0]  cfg_prdata,
  output logic                   cfg_pready
);

  logic [CFG_DATA_W-1:0] expected_length_r, expected_length_nxt;
  rld_state_t            state_r, state_nxt;
  rld_result_t           step_res;
  rld_result_t           res_r, res_nxt;
  reg_index_t            reg_idx;
  logic                  cfg_wr;
  logic                  in_fire;

  // configuration port
  assign reg_idx    = reg_index_t'(cfg_paddr[CFG_ADDR_W-1:2]);
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    expected_length_nxt = expected_length_r;
    if (cfg_wr && reg_idx == REG_EXPECTED_LENGTH) expected_length_nxt = cfg_pwdata;
  end

  always_comb begin
    case (reg_idx)
      REG_EXPECTED_LENGTH: cfg_prdata = expected_length_r;
      default:             cfg_prdata = '0;
    endcase
  end

  // decode step
  rld_step u_step (
    .cur_state       (state_r),
    .enc_byte        (in_ch.enc_byte),
    .end_mark        (in_ch.end_mark),
    .expected_length (expected_length_r),
    .nxt_state       (state_nxt),
    .result          (step_res)
  );

  assign in_ch.ready = !res_r.valid || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_comb begin
    res_nxt = res_r;
    if (in_fire) begin
      res_nxt = step_res;
    end else if (out_ch.ready) begin
      res_nxt.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_length_r <= '0;
      state_r           <= '0;
      res_r.valid       <= 1'b0;
    end else begin
      expected_length_r <= expected_length_nxt;
      if (in_fire) state_r <= state_nxt;
      res_r.valid <= res_nxt.valid;
    end
    res_r.out_byte     <= res_nxt.out_byte;
    res_r.repeat_count <= res_nxt.repeat_count;
    res_r.status       <= res_nxt.status;
  end

  assign out_ch.valid        = res_r.valid;
  assign out_ch.out_byte     = res_r.out_byte;
  assign out_ch.repeat_count = res_r.repeat_count;
  assign out_ch.status       = res_r.status;

  // an end marker always leaves a fresh column behind
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.end_mark) |=>
      (state_r.mode == MODE_HEADER && state_r.produced == '0 &&
       state_r.hdr_shift == '0))
    else $error("end marker did not clear the parse state");

  // status results carry no byte and no count
  a_status_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (res_r.valid && res_r.status != ST_DATA) |->
      (res_r.out_byte == '0 && res_r.repeat_count == '0))
    else $error("status result carries payload");

  // error mode always holds the code of the error that caused it
  a_error_code: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.mode == MODE_ERROR) |->
      (state_r.err_code == ST_OVERFLOW || state_r.err_code == ST_ZERO ||
       state_r.err_code == ST_EXCEEDS))
    else $error("error mode without an error code");

  // literal and run modes always have bytes outstanding
  a_count_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.mode == MODE_LITERAL || state_r.mode == MODE_RUN) |->
      (state_r.literal_left != '0 && state_r.hdr_shift == '0))
    else $error("block body entered with no count");

endmodule

// ===== hw/rtl/rld_step.sv =====
// rld_step: next-state and result logic for one encoded byte or end marker
// depends on rld_pkg; purely combinational, registered by the top level

module rld_step import rld_pkg::*; (
  input  rld_state_t             cur_state,
  input  logic [BYTE_W-1:0]      enc_byte,
  input  logic                   end_mark,
  input  logic [CFG_DATA_W-1:0]  expected_length,
  output rld_state_t             nxt_state,
  output rld_result_t            result
);

  logic [HDR_SHIFT_W-1:0] idx;
  logic [HDR_ACC_W-1:0]   accum_new;
  logic [HDR_ACC_W-2:0]   count;
  logic [LENGTH_BITS-1:0] cap;
  logic [LENGTH_BITS-1:0] limit;
  logic [LENGTH_BITS-1:0] headroom;
  logic                   hdr_more;
  logic                   hdr_ovf;
  logic                   cnt_zero;
  logic                   cnt_exceeds;
  logic                   len_match;
  mode_t                  nxt_mode;

  assign idx = (cur_state.hdr_shift > HDR_SHIFT_W'(HDR_LAST)) ?
               HDR_SHIFT_W'(HDR_LAST) : cur_state.hdr_shift;

  // seven payload bits per header byte; the last byte keeps only bit 0
  assign accum_new = cur_state.hdr_accum |
                     (HDR_ACC_W'(enc_byte[HDR_DIGIT_W-1:0]) << (6'(idx) * 6'd7));

  assign hdr_more = enc_byte[BYTE_W-1];
  assign hdr_ovf  = hdr_more && (idx == HDR_SHIFT_W'(HDR_LAST));
  assign count    = accum_new[HDR_ACC_W-1:1];
  assign cnt_zero = (count == '0);

  assign cap      = {LENGTH_BITS{1'b1}};
  assign limit    = (64'(expected_length) < 64'(cap)) ? LENGTH_BITS'(expected_length) : cap;
  assign headroom = limit - cur_state.produced;
  // a limit lowered below the produced count leaves no room to fail against
  assign cnt_exceeds = (limit >= cur_state.produced) &&
                       (count > (HDR_ACC_W-1)'(headroom));
  assign len_match   = (64'(cur_state.produced) == 64'(expected_length));

  // next mode
  always_comb begin
    nxt_mode = cur_state.mode;
    if (end_mark) begin
      nxt_mode = MODE_HEADER;
    end else begin
      case (cur_state.mode)
        MODE_HEADER: begin
          if (hdr_more) begin
            if (hdr_ovf) nxt_mode = MODE_ERROR;
          end else if (cnt_zero || cnt_exceeds) begin
            nxt_mode = MODE_ERROR;
          end else begin
            nxt_mode = accum_new[0] ? MODE_RUN : MODE_LITERAL;
          end
        end
        MODE_RUN: begin
          nxt_mode = MODE_HEADER;
        end
        MODE_LITERAL: begin
          if (cur_state.literal_left == LENGTH_BITS'(1)) nxt_mode = MODE_HEADER;
        end
        MODE_ERROR: begin
          nxt_mode = MODE_ERROR;
        end
        default: begin
          nxt_mode = MODE_HEADER;
        end
      endcase
    end
  end

  // datapath and result
  always_comb begin
    nxt_state      = cur_state;
    nxt_state.mode = nxt_mode;
    result         = '0;
    result.status  = ST_DATA;
    if (end_mark) begin
      nxt_state.hdr_accum    = '0;
      nxt_state.hdr_shift    = '0;
      nxt_state.literal_left = '0;
      nxt_state.produced     = '0;
      nxt_state.err_code     = ST_DATA;
      result.valid = (cur_state.mode != MODE_ERROR);
      if (cur_state.mode != MODE_HEADER || cur_state.hdr_shift != '0) begin
        result.status = ST_TRUNC;
      end else begin
        result.status = len_match ? ST_DONE : ST_MISMATCH;
      end
    end else begin
      case (cur_state.mode)
        MODE_HEADER: begin
          nxt_state.hdr_accum = accum_new;
          if (hdr_more) begin
            if (hdr_ovf) begin
              nxt_state.err_code = ST_OVERFLOW;
              result.valid       = 1'b1;
              result.status      = ST_OVERFLOW;
            end else begin
              nxt_state.hdr_shift = idx + HDR_SHIFT_W'(1);
            end
          end else if (cnt_zero) begin
            nxt_state.err_code = ST_ZERO;
            result.valid       = 1'b1;
            result.status      = ST_ZERO;
          end else if (cnt_exceeds) begin
            nxt_state.err_code = ST_EXCEEDS;
            result.valid       = 1'b1;
            result.status      = ST_EXCEEDS;
          end else begin
            nxt_state.literal_left = LENGTH_BITS'(count);
            nxt_state.hdr_accum    = '0;
            nxt_state.hdr_shift    = '0;
          end
        end
        MODE_RUN: begin
          nxt_state.produced     = cur_state.produced + cur_state.literal_left;
          nxt_state.literal_left = '0;
          result.valid           = 1'b1;
          result.out_byte        = enc_byte;
          result.repeat_count    = REPEAT_W'(cur_state.literal_left);
        end
        MODE_LITERAL: begin
          nxt_state.produced     = cur_state.produced + LENGTH_BITS'(1);
          nxt_state.literal_left = cur_state.literal_left - LENGTH_BITS'(1);
          result.valid           = 1'b1;
          result.out_byte        = enc_byte;
          result.repeat_count    = REPEAT_W'(1);
        end
        default: begin
          // error mode swallows bytes until the end marker
        end
      endcase
    end
  end

endmodule
